// File: rtl/pfc_pkg.sv
// Package for the pixel format converter: mode codes, field widths and the
// result and push records shared by the core, the result queue and the top level.
// No dependencies.
package pfc_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 12;
  localparam int NIB_W   = 4;

  // Conversion mode register codes.
  typedef enum logic [1:0] {
    MODE_RGB12  = 2'd0,
    MODE_PACK   = 2'd1,
    MODE_UNPACK = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Position of a byte within its group.
  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2,
    PHASE_STRAY  = 2'd3
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  // Results produced by one input transaction, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: rtl/pfc_if.sv
// Stream interfaces of the pixel format converter: source bytes in, results out.
// Depends on pfc_pkg for the field widths.
interface pfc_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfc_pkg::BYTE_W-1:0] source_byte;
  logic                       start_of_frame;

  modport source (output valid, output source_byte, output start_of_frame, input ready);
  modport sink   (input valid, input source_byte, input start_of_frame, output ready);
endinterface

interface pfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfc_pkg::VALUE_W-1:0] out_value;
  logic                        out_last;

  modport source (output valid, output out_value, output out_last, input ready);
  modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// File: rtl/pfc_core.sv
// Conversion core: mode register, byte phase and held bytes, and the results
// that each accepted byte produces. Depends on pfc_pkg.
module pfc_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_wr_data,
  input  logic                        accept,
  input  logic [pfc_pkg::BYTE_W-1:0]  source_byte,
  input  logic                        start_of_frame,
  output pfc_pkg::mode_t              mode,
  output pfc_pkg::push_t              push
);

  pfc_pkg::phase_t            phase;
  pfc_pkg::phase_t            phase_next;
  logic [pfc_pkg::BYTE_W-1:0] held_first;
  logic [pfc_pkg::BYTE_W-1:0] held_first_next;
  logic [pfc_pkg::BYTE_W-1:0] held_second;
  logic [pfc_pkg::BYTE_W-1:0] held_second_next;
  pfc_pkg::phase_t            eff_phase;
  logic [pfc_pkg::NIB_W-1:0]  hi_nib;
  logic [pfc_pkg::NIB_W-1:0]  lo_nib;

  assign hi_nib = source_byte[pfc_pkg::BYTE_W-1 -: pfc_pkg::NIB_W];
  assign lo_nib = source_byte[pfc_pkg::NIB_W-1:0];

  // Decode the byte against the current phase and build the results.
  always_comb begin
    eff_phase        = start_of_frame ? pfc_pkg::PHASE_FIRST : phase;
    phase_next       = eff_phase;
    held_first_next  = held_first;
    held_second_next = held_second;
    push             = '0;
    case (mode)
      pfc_pkg::MODE_RGB12: begin
        if (eff_phase == pfc_pkg::PHASE_FIRST) begin
          held_first_next = source_byte;
          phase_next      = pfc_pkg::PHASE_SECOND;
        end else if (eff_phase == pfc_pkg::PHASE_SECOND) begin
          held_second_next = source_byte;
          phase_next       = pfc_pkg::PHASE_THIRD;
        end else begin
          // A stray phase counts as the blue byte.
          phase_next         = pfc_pkg::PHASE_FIRST;
          push.count         = 2'd1;
          push.first.value   = {held_first[pfc_pkg::BYTE_W-1 -: pfc_pkg::NIB_W],
                                held_second[pfc_pkg::BYTE_W-1 -: pfc_pkg::NIB_W],
                                hi_nib};
          push.first.last    = 1'b1;
        end
      end
      pfc_pkg::MODE_PACK: begin
        if (eff_phase == pfc_pkg::PHASE_FIRST) begin
          held_first_next = source_byte;
          phase_next      = pfc_pkg::PHASE_SECOND;
        end else begin
          // The second byte is ORed in whole, not masked.
          phase_next       = pfc_pkg::PHASE_FIRST;
          push.count       = 2'd1;
          push.first.value = {{pfc_pkg::NIB_W{1'b0}},
                              held_first[pfc_pkg::NIB_W-1:0] | hi_nib, lo_nib};
          push.first.last  = 1'b1;
        end
      end
      pfc_pkg::MODE_UNPACK: begin
        phase_next        = pfc_pkg::PHASE_FIRST;
        push.count        = 2'd2;
        push.first.value  = {{(pfc_pkg::VALUE_W-pfc_pkg::NIB_W){1'b0}}, hi_nib};
        push.first.last   = 1'b0;
        push.second.value = {{(pfc_pkg::VALUE_W-pfc_pkg::NIB_W){1'b0}}, lo_nib};
        push.second.last  = 1'b1;
      end
      default: begin
        // No conversion: only the start-of-frame clear takes effect.
        phase_next = eff_phase;
      end
    endcase
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  // Mode register and byte phase; a mode write restarts the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= pfc_pkg::MODE_NONE;
      phase <= pfc_pkg::PHASE_FIRST;
    end else if (cfg_wr_en) begin
      mode  <= pfc_pkg::mode_t'(cfg_wr_data);
      phase <= pfc_pkg::PHASE_FIRST;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Held bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_first  <= '0;
      held_second <= '0;
    end else if (accept) begin
      held_first  <= held_first_next;
      held_second <= held_second_next;
    end
  end

endmodule

// File: rtl/pfc_result_queue.sv
// Small result queue: two results in a cycle at most, one out on out_ready.
// Depends on pfc_pkg for the result and push records.
module pfc_result_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pfc_pkg::push_t               push,
  output logic                         room,
  output logic [$clog2(DEPTH+1)-1:0]   level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pfc_pkg::result_t             out_item
);

  // DEPTH must be a power of two, at least 2 (unchecked), so the pointers wrap.
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

  pfc_pkg::result_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    level_next;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_item  = entries[rd_ptr];
  assign room      = (level <= ROOM_LIMIT);

  assign level_next = level + CW'(push.count) - {{(CW-1){1'b0}}, pop};

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      level <= level_next;
    end
  end

  // Entry storage; the second result goes right after the first.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push.second;
    end
  end

endmodule

// File: rtl/pixel_format_converter.sv
// Pixel format converter top level: one source byte per transaction in, one
// converted word per transaction out. Depends on pfc_pkg, pfc_if, pfc_core
// and pfc_result_queue.
// A result enters the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the queue has room for two results; in
// unpack mode each byte yields two results for the single result port.
// Reset clears the mode to no conversion, the byte phase, held bytes and queue.
module pixel_format_converter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  pfc_in_if.sink      in_ch,
  pfc_out_if.source   out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pfc_pkg::mode_t   mode;
  pfc_pkg::push_t   push;
  pfc_pkg::result_t head;
  logic             room;
  logic [CW-1:0]    level;
  logic             in_accept;

  // A byte is taken whenever the queue has space for two results.
  assign in_ch.ready = room;
  assign in_accept   = in_ch.valid && in_ch.ready;

  pfc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (in_accept),
    .source_byte    (in_ch.source_byte),
    .start_of_frame (in_ch.start_of_frame),
    .mode           (mode),
    .push           (push)
  );

  pfc_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .level     (level),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (head)
  );

  assign out_ch.out_value = head.value;
  assign out_ch.out_last  = head.last;

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst) level <= CW'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A byte in no-conversion mode produces no result.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode == pfc_pkg::MODE_NONE) |-> push.count == 2'd0)
    else $error("result pushed in no-conversion mode");

  // After any push, the queue offers a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |=> out_ch.valid)
    else $error("pushed result not offered");

  // An unpacked byte always yields exactly two results.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode == pfc_pkg::MODE_UNPACK) |-> push.count == 2'd2)
    else $error("unpack did not push two results");

endmodule

// File: tb/pfc_result_checker.sv
// Result checker for the pixel format converter: watches the config port and both
// streams, predicts each converted word and compares it with what the block returns.
// Depends on pfc_pkg and the pfc_in_if / pfc_out_if interfaces.
module pfc_result_checker (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  pfc_in_if         in_ch,
  pfc_out_if        out_ch,
  output int        error_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted converter state.
  pfc_pkg::mode_t                 conv_mode;
  pfc_pkg::phase_t                group_pos;
  logic [pfc_pkg::BYTE_W-1:0]     held_first;
  logic [pfc_pkg::BYTE_W-1:0]     held_second;
  pfc_pkg::result_t               expected_words[$];
  pfc_pkg::result_t               want;
  int                             errors = 0;

  // Work out the words that one accepted source byte produces and queue them.
  task automatic convert_byte(input logic [pfc_pkg::BYTE_W-1:0] src, input logic sof);
    pfc_pkg::result_t word;
    if (sof) begin
      group_pos = pfc_pkg::PHASE_FIRST;
    end
    case (conv_mode)
      pfc_pkg::MODE_RGB12: begin
        if (group_pos == pfc_pkg::PHASE_FIRST) begin
          held_first = src;
          group_pos  = pfc_pkg::PHASE_SECOND;
        end else if (group_pos == pfc_pkg::PHASE_SECOND) begin
          held_second = src;
          group_pos   = pfc_pkg::PHASE_THIRD;
        end else begin
          // Any later position counts as the blue byte.
          group_pos  = pfc_pkg::PHASE_FIRST;
          word.value = {held_first[7:4], held_second[7:4], src[7:4]};
          word.last  = 1'b1;
          expected_words.push_back(word);
        end
      end
      pfc_pkg::MODE_PACK: begin
        if (group_pos == pfc_pkg::PHASE_FIRST) begin
          held_first = src;
          group_pos  = pfc_pkg::PHASE_SECOND;
        end else begin
          // The second pixel is not masked, so its high nibble ORs into the result.
          group_pos  = pfc_pkg::PHASE_FIRST;
          word.value = {4'h0, {held_first[3:0], 4'h0} | src};
          word.last  = 1'b1;
          expected_words.push_back(word);
        end
      end
      pfc_pkg::MODE_UNPACK: begin
        group_pos  = pfc_pkg::PHASE_FIRST;
        word.value = {8'h00, src[7:4]};
        word.last  = 1'b0;
        expected_words.push_back(word);
        word.value = {8'h00, src[3:0]};
        word.last  = 1'b1;
        expected_words.push_back(word);
      end
      default: begin
      end
    endcase
  endtask

  // Track config writes and input transactions, then check each output transaction.
  always @(posedge clk) begin
    if (rst) begin
      conv_mode   = pfc_pkg::MODE_NONE;
      group_pos   = pfc_pkg::PHASE_FIRST;
      held_first  = '0;
      held_second = '0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        conv_mode = pfc_pkg::mode_t'(cfg_wr_data);
        group_pos = pfc_pkg::PHASE_FIRST;
      end
      if (in_ch.valid && in_ch.ready) begin
        convert_byte(in_ch.source_byte, in_ch.start_of_frame);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: ERROR unexpected result, expected none, got value %03h last %0b",
                   $time, out_ch.out_value, out_ch.out_last);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.out_value !== want.value) begin
            errors++;
            $display("%0t: ERROR out_value expected %03h, got %03h",
                     $time, want.value, out_ch.out_value);
          end
          if (out_ch.out_last !== want.last) begin
            errors++;
            $display("%0t: ERROR out_last expected %0b, got %0b",
                     $time, want.last, out_ch.out_last);
          end
        end
      end
    end
    error_count <= errors;
    outstanding <= expected_words.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the pixel format converter testbench: clock, reset, stimulus and verdict.
// Depends on pfc_pkg, the stream interfaces, pixel_format_converter and pfc_result_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;
  int         error_count;
  int         outstanding;
  int         cycles = 0;

  pfc_in_if  in_ch();
  pfc_out_if out_ch();

  pixel_format_converter uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  pfc_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result back-pressure: bursts of ready, mostly short stalls, a few long ones.
  initial begin
    int pick;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (pick < 75) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else if (pick < 95) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  // Offer one byte and return at the edge where the transaction completes.
  task automatic send_byte(input logic [pfc_pkg::BYTE_W-1:0] src, input logic sof);
    in_ch.valid          <= 1'b1;
    in_ch.source_byte    <= src;
    in_ch.start_of_frame <= sof;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Send a byte, then idle the input for a random number of cycles unless calm.
  task automatic feed_byte(input logic [pfc_pkg::BYTE_W-1:0] src, input logic sof,
                           input bit calm);
    int pick;
    int gap;
    send_byte(src, sof);
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 25);
    if (gap != 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.source_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input off until every predicted word has come back, then let it settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Change the conversion mode while the block is idle.
  task automatic set_mode(input pfc_pkg::mode_t mode);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    pfc_pkg::mode_t              mode;
    int                          counted;
    int                          seg_len;
    int                          group;
    int                          pick;
    bit                          calm;
    logic                        sof;
    logic [pfc_pkg::BYTE_W-1:0]  src;

    in_ch.valid          <= 1'b0;
    in_ch.source_byte    <= '0;
    in_ch.start_of_frame <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= pfc_pkg::MODE_NONE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the reset mode converts nothing, start of frame included.
    feed_byte(8'h5A, 1'b1, 1'b0);
    feed_byte(8'hC3, 1'b0, 1'b0);

    // RGB to 12-bit: extreme bytes, then a start of frame in the middle of a group.
    set_mode(pfc_pkg::MODE_RGB12);
    feed_byte(8'hFF, 1'b1, 1'b0);
    feed_byte(8'h00, 1'b0, 1'b0);
    feed_byte(8'hFF, 1'b0, 1'b0);
    feed_byte(8'hAB, 1'b0, 1'b0);
    feed_byte(8'hCD, 1'b0, 1'b0);
    feed_byte(8'h12, 1'b1, 1'b0);
    feed_byte(8'h34, 1'b0, 1'b0);
    feed_byte(8'h56, 1'b0, 1'b0);
    // Leave a group half done so the next mode write has to clear the phase.
    feed_byte(8'h77, 1'b0, 1'b0);

    // Pack: unmasked second byte, extremes, restart on start of frame.
    set_mode(pfc_pkg::MODE_PACK);
    feed_byte(8'h0F, 1'b0, 1'b1);
    feed_byte(8'hF0, 1'b0, 1'b1);
    feed_byte(8'hFF, 1'b0, 1'b1);
    feed_byte(8'hFF, 1'b0, 1'b1);
    feed_byte(8'h3C, 1'b0, 1'b0);
    feed_byte(8'h81, 1'b1, 1'b0);
    feed_byte(8'h7E, 1'b0, 1'b0);
    feed_byte(8'h44, 1'b0, 1'b0);

    // Unpack: two words per byte.
    set_mode(pfc_pkg::MODE_UNPACK);
    feed_byte(8'h00, 1'b0, 1'b1);
    feed_byte(8'hFF, 1'b1, 1'b1);
    feed_byte(8'hA5, 1'b0, 1'b0);

    set_mode(pfc_pkg::MODE_NONE);
    feed_byte(8'h99, 1'b1, 1'b0);

    // Random segments: a random mode each, mostly well-formed frames of random bytes,
    // with an occasional start of frame that breaks a group.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode = pfc_pkg::mode_t'($urandom_range(0, 3));
      set_mode(mode);
      calm = ($urandom_range(0, 3) == 0);
      case (mode)
        pfc_pkg::MODE_RGB12: group = 3;
        pfc_pkg::MODE_PACK:  group = 2;
        default:             group = 1;
      endcase
      seg_len = (mode == pfc_pkg::MODE_NONE) ? $urandom_range(2, 8) : $urandom_range(15, 60);
      for (int i = 0; i < seg_len; i++) begin
        if (i == 0) sof = ($urandom_range(0, 3) != 0);
        else if (i % group == 0) sof = ($urandom_range(0, 15) == 0);
        else sof = ($urandom_range(0, 31) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 10) src = 8'h00;
        else if (pick < 20) src = 8'hFF;
        else src = 8'($urandom);
        feed_byte(src, sof, calm);
        if (mode != pfc_pkg::MODE_NONE) counted++;
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: pixel_format_converter.f
rtl/pfc_pkg.sv
rtl/pfc_if.sv
rtl/pfc_core.sv
rtl/pfc_result_queue.sv
rtl/pixel_format_converter.sv
tb/pfc_result_checker.sv
tb/testbench.sv
